[sv/plf_pkg.sv]
// playfair cipher package: letter codes, input kinds and the queue word type
// shared by the front, the queue, the back and the top level; no dependencies

package plf_pkg;

  localparam int unsigned SIDE    = 5;
  localparam int unsigned LETTERS = 26;

  localparam logic [4:0] IDX_I = 5'd8;
  localparam logic [4:0] IDX_J = 5'd9;
  localparam logic [4:0] IDX_X = 5'd23;
  localparam logic [4:0] IDX_LAST = 5'(LETTERS - 1);

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7a;
  localparam logic [6:0] CHAR_OUT_A = 7'h41;

  // configuration register index
  localparam logic [0:0] REG_CIPHER_MODE = 1'd0;

  typedef enum logic [1:0] {
    FN_KEY  = 2'd0,
    FN_FILL = 2'd1,
    FN_TEXT = 2'd2,
    FN_END  = 2'd3
  } plf_func_t;

  // one classified word between front and back
  typedef struct packed {
    plf_func_t  func;
    logic [4:0] letter;
  } plf_item_t;

  // bit 5 set for a letter, bits 4:0 the letter index with j folded onto i
  function automatic logic [5:0] letter_index(input logic [7:0] ch);
    logic [7:0] off;
    logic       ok;
    off = 8'd0;
    ok  = 1'b0;
    if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
      off = ch - CHAR_UP_A;
      ok  = 1'b1;
    end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
      off = ch - CHAR_LO_A;
      ok  = 1'b1;
    end
    if (off[4:0] == IDX_J) begin
      off = {3'd0, IDX_I};
    end
    return {ok, off[4:0]};
  endfunction

endpackage

[sv/plf_front.sv]
// playfair front: takes input words, classifies them and drops no-op words
// depends on plf_pkg

module plf_front (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // char_in
  input  logic [1:0]       s_tuser,   // func
  input  logic             q_full,
  output logic             push,
  output plf_pkg::plf_item_t push_item
);
  import plf_pkg::*;

  logic [5:0] code;
  plf_func_t  func;
  logic       useful;

  assign code = letter_index(s_tdata);
  assign func = plf_func_t'(s_tuser);

  // non-letters change nothing for key and text words
  always_comb begin
    unique case (func)
      FN_KEY, FN_TEXT: useful = code[5];
      FN_FILL, FN_END: useful = 1'b1;
      default:         useful = 1'b0;
    endcase
  end

  assign s_tready       = !q_full;
  assign push           = s_tvalid && s_tready && useful;
  assign push_item.func = func;
  assign push_item.letter = code[4:0];

endmodule

[sv/plf_fifo.sv]
// playfair queue: short fifo of classified words between front and back
// depends on plf_pkg

module plf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  plf_pkg::plf_item_t push_item,
  input  logic               pop,
  output plf_pkg::plf_item_t head,
  output logic               full,
  output logic               empty
);
  import plf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  plf_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[sv/plf_back.sv]
// playfair back: builds the key square, pairs text letters and looks up
// the cipher letters through two small memories; depends on plf_pkg

module plf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cipher_mode,
  input  plf_pkg::plf_item_t head,
  input  logic               q_empty,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [6:0]         m_tdata_char,
  output logic               m_tlast
);
  import plf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_LOOK,
    S_ROUTE,
    S_LOAD,
    S_EMIT0,
    S_EMIT1
  } state_t;

  state_t        state;
  logic [LETTERS-1:0] letter_used;
  logic [2:0]    fill_row;
  logic [2:0]    fill_col;
  logic [4:0]    fill_k;
  logic [4:0]    held_letter;
  logic          held_valid;
  logic [4:0]    pair_a;
  logic [4:0]    pair_b;

  // letter -> {row, col}, and cell -> letter
  logic [5:0]    place_mem [LETTERS];
  logic [4:0]    square_mem [SIDE*SIDE];
  logic [5:0]    place_rd_a;
  logic [5:0]    place_rd_b;
  logic [4:0]    cell_rd_a;
  logic [4:0]    cell_rd_b;

  logic          square_full;
  logic          place_req;
  logic [4:0]    place_idx;
  logic          place_ok;
  logic [4:0]    fill_addr;
  logic [2:0]    ra, ca, rb, cb;
  logic [4:0]    addr_a;
  logic [4:0]    addr_b;

  function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  // cyclic neighbour on a side of five, down or up
  function automatic logic [2:0] step(input logic [2:0] p, input logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (p == 3'd0) ? 3'(SIDE - 1) : p - 3'd1;
    end else begin
      r = (p == 3'(SIDE - 1)) ? 3'd0 : p + 3'd1;
    end
    return r;
  endfunction

  assign square_full = (fill_row == 3'(SIDE));
  assign fill_addr   = cell_addr(fill_row, fill_col);
  assign pop         = (state == S_IDLE) && !q_empty;

  always_comb begin
    place_req = 1'b0;
    place_idx = head.letter;
    if (pop && head.func == FN_KEY) begin
      place_req = 1'b1;
    end else if (state == S_FILL) begin
      place_req = (fill_k != IDX_J);
      place_idx = fill_k;
    end
  end

  assign place_ok = place_req && !letter_used[place_idx] && !square_full;

  always_comb begin
    {ra, ca} = place_rd_a;
    {rb, cb} = place_rd_b;
    if (ra == rb) begin
      addr_a = cell_addr(ra, step(ca, cipher_mode));
      addr_b = cell_addr(rb, step(cb, cipher_mode));
    end else if (ca == cb) begin
      addr_a = cell_addr(step(ra, cipher_mode), ca);
      addr_b = cell_addr(step(rb, cipher_mode), cb);
    end else begin
      addr_a = cell_addr(ra, cb);
      addr_b = cell_addr(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (place_ok) begin
      place_mem[place_idx]  <= {fill_row, fill_col};
      square_mem[fill_addr] <= place_idx;
    end
    place_rd_a <= place_mem[pair_a];
    place_rd_b <= place_mem[pair_b];
    cell_rd_a  <= square_mem[addr_a];
    cell_rd_b  <= square_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      letter_used  <= '0;
      fill_row     <= '0;
      fill_col     <= '0;
      fill_k       <= '0;
      held_letter  <= '0;
      held_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
    end else begin
      if (place_ok) begin
        letter_used[place_idx] <= 1'b1;
        if (fill_col == 3'(SIDE - 1)) begin
          fill_col <= '0;
          fill_row <= fill_row + 3'd1;
        end else begin
          fill_col <= fill_col + 3'd1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.func)
              FN_KEY: begin
              end
              FN_FILL: begin
                fill_k <= '0;
                state  <= S_FILL;
              end
              FN_TEXT: begin
                if (!held_valid) begin
                  held_letter <= head.letter;
                  held_valid  <= 1'b1;
                end else if (!cipher_mode && held_letter == head.letter) begin
                  // doubled letter: pad with x and keep the new one held
                  pair_a <= held_letter;
                  pair_b <= IDX_X;
                  state  <= S_LOOK;
                end else begin
                  held_valid <= 1'b0;
                  pair_a     <= held_letter;
                  pair_b     <= head.letter;
                  state      <= S_LOOK;
                end
              end
              FN_END: begin
                if (held_valid) begin
                  held_valid <= 1'b0;
                  if (!cipher_mode) begin
                    pair_a <= held_letter;
                    pair_b <= IDX_X;
                    state  <= S_LOOK;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FILL: begin
          fill_k <= fill_k + 5'd1;
          if (fill_k == IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_LOOK:  state <= S_ROUTE;
        S_ROUTE: state <= S_LOAD;
        S_LOAD: begin
          m_tvalid     <= 1'b1;
          m_tdata_char <= CHAR_OUT_A + {2'b00, cell_rd_a};
          m_tlast      <= 1'b0;
          state        <= S_EMIT0;
        end
        S_EMIT0: begin
          if (m_tready) begin
            m_tdata_char <= CHAR_OUT_A + {2'b00, cell_rd_b};
            m_tlast      <= 1'b1;
            state        <= S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            m_tlast  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_only_emitting: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == S_EMIT0 || state == S_EMIT1))
    else $error("result word shown outside the emit states");

  a_used_matches_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(letter_used) == int'(cell_addr(fill_row, fill_col)))
    else $error("used letters disagree with the fill position");

  a_fill_completes: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && fill_k == IDX_LAST) |=> square_full && fill_col == 3'd0)
    else $error("key square not full after the fill walk");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_col < 3'(SIDE) && fill_row <= 3'(SIDE))
    else $error("fill position out of the square");
`endif

endmodule

[sv/playfair_cipher.sv]
// playfair cipher over a 5x5 key square: a key or text word enters the queue in the
// cycle it is accepted; the back takes one queued word per cycle while it is idle, a key-end
// fill walks 26 letters, and the first result of a pair is offered after the look, route
// and load states that follow its second letter, the second in the cycle after the first is
// taken, so a pair holds the back until both of its results are taken.
// synchronous reset clears the queue, fill position, used letters and held letter
module playfair_cipher #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_in
  input  logic [1:0] s_tuser,   // func
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // char_out [6:0], zero [7]
  output logic       m_tlast,   // pair_last
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import plf_pkg::*;

  logic      cipher_mode;
  logic      reg_hit;
  logic      push;
  plf_item_t push_item;
  plf_item_t head;
  logic      q_full;
  logic      q_empty;
  logic      pop;
  logic [6:0] char_out;

  // the byte offset within a register is not decoded
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_CIPHER_MODE);
  assign prdata  = reg_hit ? {31'd0, cipher_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cipher_mode <= pwdata[0];
    end
  end

  plf_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  plf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  plf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cipher_mode  (cipher_mode),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata_char (char_out),
    .m_tlast      (m_tlast)
  );

  assign m_tdata = {1'b0, char_out};

endmodule

[tb/playfair_cipher_test.sv]
// self-checking testbench for playfair_cipher: builds one key square, then streams
// directed and random text words under several idling phases in both cipher modes
// depends on plf_pkg and playfair_cipher only
`timescale 1ns / 100ps

module playfair_cipher_test;
  import plf_pkg::*;

  localparam logic [2:0]  ADDR_CIPHER_MODE = {REG_CIPHER_MODE, 2'b00};
  localparam logic        MODE_ENCRYPT     = 1'b0;
  localparam logic        MODE_DECRYPT     = 1'b1;
  localparam int unsigned CELL_COUNT       = SIDE * SIDE;
  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned DRAIN_CYCLES     = 200;
  localparam int unsigned HOLDOFF_CYCLES   = 400;

  typedef struct packed {
    plf_func_t  fn;
    logic [7:0] ch;
  } char_word_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } cipher_letter_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // char_in
  logic [1:0]  s_tuser = 2'd0;   // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // char_out [6:0], zero [7]
  logic        m_tlast;          // pair_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  char_word_t     send_q[$];
  cipher_letter_t cipher_due[$];
  cipher_letter_t due_head;

  // local copy of the key square and pairing state
  logic [4:0]  sq_cell[CELL_COUNT];
  logic        sq_used[LETTERS];
  logic [4:0]  sq_place[LETTERS];
  int unsigned sq_fill;
  logic [4:0]  held_idx;
  logic        held_ok;
  logic        model_mode;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        holdoff_go = 1'b0;
  logic        holdoff_seen = 1'b0;
  int unsigned holdoff_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  playfair_cipher dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // {is_letter, index}, lower case folded up and j onto i
  function automatic logic [5:0] fold_char(logic [7:0] c);
    logic [7:0] k;
    k = c;
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      k = c - (CHAR_LO_A - CHAR_UP_A);
    end
    if (k < CHAR_UP_A || k > CHAR_UP_Z) begin
      return 6'd0;
    end
    k = k - CHAR_UP_A;
    if (k[4:0] == IDX_J) begin
      k = {3'd0, IDX_I};
    end
    return {1'b1, k[4:0]};
  endfunction

  function automatic void place_key(logic [4:0] idx);
    if (!sq_used[idx] && sq_fill < CELL_COUNT) begin
      sq_cell[sq_fill] = idx;
      sq_place[idx] = 5'(sq_fill);
      sq_used[idx] = 1'b1;
      sq_fill++;
    end
  endfunction

  function automatic logic [6:0] square_char(int unsigned r, int unsigned c);
    return CHAR_OUT_A + 7'(sq_cell[(r % SIDE) * SIDE + (c % SIDE)]);
  endfunction

  function automatic void push_pair(logic [4:0] a, logic [4:0] b);
    int unsigned ra, ca, rb, cb, sh;
    logic [6:0] ya, yb;
    ra = sq_place[a] / SIDE;
    ca = sq_place[a] % SIDE;
    rb = sq_place[b] / SIDE;
    cb = sq_place[b] % SIDE;
    // a step left is a step right by side-1, cyclic
    sh = (model_mode == MODE_DECRYPT) ? SIDE - 1 : 1;
    if (ra == rb) begin
      ya = square_char(ra, ca + sh);
      yb = square_char(rb, cb + sh);
    end else if (ca == cb) begin
      ya = square_char(ra + sh, ca);
      yb = square_char(rb + sh, cb);
    end else begin
      ya = square_char(ra, cb);
      yb = square_char(rb, ca);
    end
    cipher_due.push_back('{ya, 1'b0});
    cipher_due.push_back('{yb, 1'b1});
  endfunction

  function automatic void playfair_step(plf_func_t fn, logic [7:0] c);
    logic [5:0] f;
    f = fold_char(c);
    case (fn)
      FN_KEY: begin
        if (f[5]) place_key(f[4:0]);
      end
      FN_FILL: begin
        for (int k = 0; k < LETTERS; k++) begin
          if (5'(k) != IDX_J) place_key(5'(k));
        end
      end
      FN_TEXT: begin
        if (f[5]) begin
          if (!held_ok) begin
            held_idx = f[4:0];
            held_ok = 1'b1;
          end else if (model_mode == MODE_ENCRYPT && held_idx == f[4:0]) begin
            // doubled letter: pair with an x, the new one stays held
            push_pair(held_idx, IDX_X);
          end else begin
            held_ok = 1'b0;
            push_pair(held_idx, f[4:0]);
          end
        end
      end
      default: begin
        if (held_ok) begin
          held_ok = 1'b0;
          if (model_mode == MODE_ENCRYPT) push_pair(held_idx, IDX_X);
        end
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= send_q[0].fn;
        s_tdata <= send_q[0].ch;
        void'(send_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_go && !holdoff_seen) begin
      holdoff_seen <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      m_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // prediction on accepted words, checking of results and register reads
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LETTERS; k++) sq_used[k] = 1'b0;
      sq_fill = 0;
      held_idx = 5'd0;
      held_ok = 1'b0;
      model_mode = MODE_ENCRYPT;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_CIPHER_MODE) model_mode = pwdata[0];
        end else if (prdata !== {31'd0, model_mode}) begin
          $error("cipher_mode: expected %h, got %h", {31'd0, model_mode}, prdata);
          fail_count++;
        end
      end
      if (s_tvalid && s_tready) playfair_step(plf_func_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) begin
        if (cipher_due.size() == 0) begin
          $error("unexpected word: char_out %h pair_last %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          due_head = cipher_due.pop_front();
          if (m_tdata !== {1'b0, due_head.ch}) begin
            $error("char_out: expected %h, got %h", {1'b0, due_head.ch}, m_tdata);
            fail_count++;
          end
          if (m_tlast !== due_head.last) begin
            $error("pair_last: expected %b, got %b", due_head.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[playfair_cipher] ERROR");
      $finish;
    end
  end

  task automatic send(plf_func_t fn, logic [7:0] c);
    send_q.push_back('{fn, c});
  endtask

  task automatic apb_cycle(logic wr, logic [2:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // upper bits of the write data are junk, only bit 0 is the mode
  task automatic set_mode(logic m);
    apb_cycle(1'b1, ADDR_CIPHER_MODE, {31'($urandom_range(32'h7fff_ffff)), m});
    apb_cycle(1'b0, ADDR_CIPHER_MODE, 32'd0);
  endtask

  // wait until every word is out, then let a queued fill run dry
  task automatic settle();
    while (send_q.size() != 0 || s_tvalid || cipher_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] any_case(logic [4:0] idx);
    return ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + 8'(idx);
  endfunction

  task automatic queue_text(int unsigned n);
    int unsigned r;
    logic [4:0] idx;
    logic [4:0] prev_idx;
    prev_idx = 5'd0;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 78) begin
        // some repeats so doubled letters come up often
        idx = (r < 14) ? prev_idx : 5'($urandom_range(LETTERS - 1));
        prev_idx = idx;
        send(FN_TEXT, any_case(idx));
      end else if (r < 86) begin
        send(FN_TEXT, 8'($urandom_range(255)));
      end else if (r < 95) begin
        send(FN_END, 8'($urandom_range(255)));
      end else if (r < 98) begin
        send(FN_KEY, 8'($urandom_range(255)));
      end else begin
        send(FN_FILL, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_mode(MODE_ENCRYPT);

    // key: case folding, j onto i, repeats and non-letters, then random letters
    send(FN_KEY, "p");
    send(FN_KEY, "L");
    send(FN_KEY, "y");
    send(FN_KEY, "J");
    send(FN_KEY, "i");
    send(FN_KEY, 8'hff);
    send(FN_KEY, "3");
    repeat (10) send(FN_KEY, any_case(5'($urandom_range(LETTERS - 1))));
    send(FN_FILL, 8'ha5);
    // square full: both of these change nothing
    send(FN_KEY, "Q");
    send(FN_FILL, 8'h00);

    // encrypt: doubled letters, doubled x, padding at text end, noise
    send(FN_TEXT, "h");
    send(FN_TEXT, "e");
    send(FN_TEXT, "l");
    send(FN_TEXT, "l");
    send(FN_TEXT, "!");
    send(FN_TEXT, "o");
    send(FN_TEXT, "X");
    send(FN_TEXT, "x");
    send(FN_END, 8'h00);
    send(FN_TEXT, "j");
    send(FN_END, 8'hff);
    send(FN_END, 8'h00);
    settle();

    // decrypt: odd letter dropped at text end, then a letter left held
    set_mode(MODE_DECRYPT);
    send(FN_TEXT, "A");
    send(FN_TEXT, "b");
    send(FN_TEXT, "z");
    send(FN_END, 8'h00);
    send(FN_TEXT, "K");
    settle();

    // held letter carries over the mode change and doubles in encrypt
    set_mode(MODE_ENCRYPT);
    send(FN_TEXT, "k");
    send(FN_END, 8'h00);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      set_mode(p[0] ? MODE_DECRYPT : MODE_ENCRYPT);
      queue_text(340);
      settle();
    end

    // block fills up behind a stalled output while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(MODE_DECRYPT);
    holdoff_go = 1'b1;
    queue_text(150);
    settle();

    if (fail_count == 0) begin
      $display("[playfair_cipher] OK");
    end else begin
      $display("[playfair_cipher] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/plf_pkg.sv
sv/plf_front.sv
sv/plf_fifo.sv
sv/plf_back.sv
sv/playfair_cipher.sv
tb/playfair_cipher_test.sv
